// File: design/sccp_pkg.sv
`default_nettype none
package sccp_pkg;

	// Unsigned 2/pi with 32 fraction bits.
	localparam logic [31:0] TWO_OVER_PI = 32'hA2F9836E;

	// Remainder magnitude |r| with 31 fraction bits; its largest value is 0.5.
	localparam int U_W = 31;

	// Queue depths and the widths of the counters that track them.
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;
	localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// Polynomial coefficients, 30 fraction bits.
	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
	localparam logic signed [31:0] C1 = 32'sd1686629690;
	localparam logic signed [31:0] C3 = -32'sd693597423;
	localparam logic signed [31:0] C5 = 32'sd85551349;
	localparam logic signed [31:0] C7 = -32'sd4930933;
	localparam logic signed [31:0] C2 = -32'sd1324675869;
	localparam logic signed [31:0] C4 = 32'sd272375234;
	localparam logic signed [31:0] C6 = -32'sd22398331;
	localparam logic signed [31:0] C8 = 32'sd970267;

	// A reduced angle, classified and ready for the polynomial pipeline.
	typedef struct packed {
		logic [U_W-1:0] u;
		logic [1:0]     quad;
		logic           rneg;
		logic           aneg;
	} sccp_item_t;

	typedef struct packed {
		logic signed [31:0] sine;
		logic signed [31:0] cosine;
	} sccp_result_t;

endpackage
`default_nettype wire

// File: design/sin_cos_quadrant_poly_deg8.sv
// Sine and cosine of an angle by quadrant reduction and two polynomials.
// Input channel: a queue-style push port. An angle on angle (signed, radians,
// ANGLE_FRAC_BITS fraction bits) is taken at a rising edge with push high and
// full low. Result channel: a queue-style pop port. While empty is low, the
// oldest result is on sine and cosine (signed Q2.30 at OUT_FRAC_BITS fraction
// bits, limited to plus or minus one); it is taken at an edge with pop high.
// An angle passes the registered reduction multiply, the middle queue, the
// five-stage Horner pipeline and the output queue. Throughput: one angle per
// cycle while full is low; each Horner stage has at most two multipliers.
// Front end (reduction and quadrant rounding) and back end (polynomials) are
// separated by a 4-entry queue; results wait in an 8-entry queue. When pop is
// held low the output queue fills, the back end stops taking items, the middle
// queue fills, and full rises; nothing is lost or repeated.
// Reset empties both queues and the pipelines; full is low after reset.
`default_nettype none
module sin_cos_quadrant_poly_deg8 #(
	parameter int ANGLE_FRAC_BITS = 24,
	parameter int OUT_FRAC_BITS   = 30
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [31:0] angle,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      sine,
	output logic signed [31:0]      cosine
);
	import sccp_pkg::*;

	localparam int ITEM_W = $bits(sccp_item_t);
	localparam int RES_W  = $bits(sccp_result_t);

	logic         mid_push;
	logic         mid_full;
	logic         mid_empty;
	logic         mid_pop;
	sccp_item_t   mid_wr;
	sccp_item_t   mid_rd;
	logic         out_push;
	logic         out_full;
	logic         out_pop;
	sccp_result_t out_wr;
	sccp_result_t out_rd;

	sccp_front #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.angle    (angle),
		.mid_push (mid_push),
		.mid_item (mid_wr),
		.mid_pop  (mid_pop)
	);

	sccp_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (mid_push),
		.wr_data  (mid_wr),
		.is_full  (mid_full),
		.rd_en    (mid_pop),
		.rd_data  (mid_rd),
		.is_empty (mid_empty)
	);

	sccp_back #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_item  (mid_rd),
		.mid_pop   (mid_pop),
		.out_push  (out_push),
		.out_item  (out_wr),
		.out_pop   (out_pop)
	);

	assign out_pop = pop && !empty;

	sccp_fifo #(
		.WIDTH(RES_W),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (out_push),
		.wr_data  (out_wr),
		.is_full  (out_full),
		.rd_en    (out_pop),
		.rd_data  (out_rd),
		.is_empty (empty)
	);

	assign sine   = out_rd.sine;
	assign cosine = out_rd.cosine;

`ifndef SYNTH
	// The front-end credit must keep the middle queue from overflowing.
	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> !mid_full)
		else $error("middle queue written while full");

	// The back-end credit must keep the output queue from overflowing.
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("output queue written while full");

	// Every result leaving the pipeline lies within plus or minus one.
	a_sine_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (out_wr.sine <= (32'sd1 <<< OUT_FRAC_BITS)) &&
			(out_wr.sine >= -(32'sd1 <<< OUT_FRAC_BITS)))
		else $error("sine out of range");

	a_cosine_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (out_wr.cosine <= (32'sd1 <<< OUT_FRAC_BITS)) &&
			(out_wr.cosine >= -(32'sd1 <<< OUT_FRAC_BITS)))
		else $error("cosine out of range");
`endif

endmodule
`default_nettype wire

// File: design/sccp_fifo.sv
`default_nettype none
module sccp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  is_full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  is_empty
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign do_wr    = wr_en && !is_full;
	assign do_rd    = rd_en && !is_empty;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

// File: design/sccp_front.sv
`default_nettype none
module sccp_front #(
	parameter int ANGLE_FRAC_BITS = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [31:0] angle,
	output logic                    mid_push,
	output sccp_pkg::sccp_item_t    mid_item,
	input  wire logic               mid_pop
);
	import sccp_pkg::*;

	localparam int FB = ANGLE_FRAC_BITS + 32;
	localparam logic [FB-1:0] HALF = {1'b1, {(FB - 1){1'b0}}};

	logic                 accept;
	logic [31:0]          amag;
	logic [MID_CNT_W-1:0] cnt_q;
	logic                 vld_s1;
	logic [63:0]          prod_s1;
	logic                 aneg_s1;
	logic [FB-1:0]        frac;
	logic [1:0]           qlo;
	logic                 round_up;
	logic [FB-1:0]        rem;

	// Every item from acceptance until the back end takes it holds a slot
	// of the middle queue, so that queue can never overflow.
	assign full   = (cnt_q == MID_CNT_W'(MID_DEPTH));
	assign accept = push && !full;
	assign amag   = angle[31] ? (32'd0 - angle) : angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			if (accept && !mid_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (mid_pop && !accept) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1 <= 64'(amag) * 64'(TWO_OVER_PI);
			aneg_s1 <= angle[31];
		end
	end

	// Round to the nearest quadrant, ties to even; when rounding up the
	// remainder is negative and its magnitude is the complement of the fraction.
	assign frac     = prod_s1[FB-1:0];
	assign qlo      = prod_s1[FB+1:FB];
	assign round_up = (frac > HALF) || ((frac == HALF) && qlo[0]);
	assign rem      = round_up ? (FB'(0) - frac) : frac;

	assign mid_push      = vld_s1;
	assign mid_item.u    = rem[FB-1:FB-U_W];
	assign mid_item.quad = round_up ? qlo + 2'd1 : qlo;
	assign mid_item.rneg = round_up;
	assign mid_item.aneg = aneg_s1;

endmodule
`default_nettype wire

// File: design/sccp_back.sv
`default_nettype none
module sccp_back #(
	parameter int OUT_FRAC_BITS = 30
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  mid_empty,
	input  wire sccp_pkg::sccp_item_t  mid_item,
	output logic                       mid_pop,
	output logic                       out_push,
	output sccp_pkg::sccp_result_t     out_item,
	input  wire logic                  out_pop
);
	import sccp_pkg::*;

	localparam int SH = 30 - OUT_FRAC_BITS;
	localparam logic [31:0] ROUND = (SH == 0) ? 32'd0 : (32'd1 << (SH - 1));

	// Product rounded half away from zero, 31 fraction bits dropped.
	function automatic logic signed [31:0] mul_rnd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		logic signed [63:0] bias;
		logic signed [63:0] sum;
		p    = 64'(a) * 64'(b);
		bias = p[63] ? 64'sd1073741823 : 64'sd1073741824;
		sum  = p + bias;
		return sum[62:31];
	endfunction

	// Clamp a Q.30 magnitude to [0, 1.0] and round it half up to the output format.
	function automatic logic [31:0] to_out(input logic signed [31:0] v);
		logic [31:0] m;
		logic [31:0] sum;
		if (v < 0) begin
			m = 32'd0;
		end else if (v > ONE_Q30) begin
			m = 32'(ONE_Q30);
		end else begin
			m = 32'(v);
		end
		sum = m + ROUND;
		return sum >> SH;
	endfunction

	logic [OUT_CNT_W-1:0] cnt_q;
	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [U_W-1:0]       u_s1, u_s2, u_s3, u_s4;
	logic signed [31:0]   r2_s1, r2_s2, r2_s3, r2_s4;
	logic signed [31:0]   s_s2, s_s3, s_s4, s_s5;
	logic signed [31:0]   c_s2, c_s3, c_s4, c_s5;
	logic [3:0]           flg_s1, flg_s2, flg_s3, flg_s4, flg_s5;
	logic signed [31:0]   u_ext;
	logic [31:0]          smag, cmag;
	logic [31:0]          sin_mag, cos_mag;
	logic                 sneg, cneg;
	logic [1:0]           quad;
	logic                 rneg, aneg;

	// Credit count: each item taken here holds a slot of the output queue
	// until the consumer pops it.
	assign mid_pop = !mid_empty && (cnt_q != OUT_CNT_W'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= mid_pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			if (mid_pop && !out_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (out_pop && !mid_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign u_ext = {1'b0, mid_item.u};

	always_ff @(posedge clk) begin
		u_s1   <= mid_item.u;
		r2_s1  <= mul_rnd(u_ext, u_ext);
		flg_s1 <= {mid_item.quad, mid_item.rneg, mid_item.aneg};

		u_s2   <= u_s1;
		r2_s2  <= r2_s1;
		s_s2   <= C5 + mul_rnd(C7, r2_s1);
		c_s2   <= C6 + mul_rnd(C8, r2_s1);
		flg_s2 <= flg_s1;

		u_s3   <= u_s2;
		r2_s3  <= r2_s2;
		s_s3   <= C3 + mul_rnd(s_s2, r2_s2);
		c_s3   <= C4 + mul_rnd(c_s2, r2_s2);
		flg_s3 <= flg_s2;

		u_s4   <= u_s3;
		r2_s4  <= r2_s3;
		s_s4   <= C1 + mul_rnd(s_s3, r2_s3);
		c_s4   <= C2 + mul_rnd(c_s3, r2_s3);
		flg_s4 <= flg_s3;

		s_s5   <= mul_rnd(s_s4, {1'b0, u_s4});
		c_s5   <= ONE_Q30 + mul_rnd(c_s4, r2_s4);
		flg_s5 <= flg_s4;
	end

	assign {quad, rneg, aneg} = flg_s5;
	assign smag = to_out(s_s5);
	assign cmag = to_out(c_s5);

	// Odd quadrants swap the polynomials; quad[1] negates both; aneg negates sine.
	always_comb begin
		if (quad[0]) begin
			sin_mag = cmag;
			sneg    = 1'b0;
			cos_mag = smag;
			cneg    = !rneg;
		end else begin
			sin_mag = smag;
			sneg    = rneg;
			cos_mag = cmag;
			cneg    = 1'b0;
		end
		if (quad[1]) begin
			sneg = !sneg;
			cneg = !cneg;
		end
		if (aneg) begin
			sneg = !sneg;
		end
	end

	assign out_push        = vld_s5;
	assign out_item.sine   = sneg ? (32'd0 - sin_mag) : sin_mag;
	assign out_item.cosine = cneg ? (32'd0 - cos_mag) : cos_mag;

endmodule
`default_nettype wire
